// ===== hw/rtl/first_order_plant_with_dead_time_defines.svh =====
// ----------------------------------------------------------------------------
// first-order plant with dead time: assertion macros
// ----------------------------------------------------------------------------
`ifndef FIRST_ORDER_PLANT_WITH_DEAD_TIME_DEFINES_SVH
`define FIRST_ORDER_PLANT_WITH_DEAD_TIME_DEFINES_SVH

// same-cycle implication, disabled while rst_n is low
`define FOPDT_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("fopdt check failed");

// next-cycle implication, disabled while rst_n is low
`define FOPDT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("fopdt check failed");

`endif

// ===== hw/rtl/fopdt_pkg.sv =====
// ----------------------------------------------------------------------------
// fopdt_pkg
// shared types, constants and codes of the first-order plant with dead time
// ----------------------------------------------------------------------------
`default_nettype none

package fopdt_pkg;

    localparam int DATA_W      = 32;
    localparam int Q_FRAC      = 16;
    localparam int CFG_AW      = 3;
    localparam int S_TDATA_W   = 160;
    localparam int M_TDATA_W   = 104;
    localparam int DIV_STEPS   = 32;
    localparam int DIV_CNT_W   = 5;

    localparam int IN_DELAY_LEN_DEF  = 16;
    localparam int OUT_DELAY_LEN_DEF = 16;

    localparam logic signed [31:0] IN_MIN_RST   = 32'sd0;
    localparam logic signed [31:0] IN_MAX_RST   = 32'sd6553600;
    localparam logic signed [31:0] OUT_MIN_RST  = 32'sd0;
    localparam logic signed [31:0] OUT_MAX_RST  = 32'sd6553600;
    localparam logic signed [31:0] GAIN_RST     = 32'sd65536;
    localparam logic signed [31:0] TAU_RST      = 32'sd65536;
    localparam logic signed [31:0] INIT_IN_RST  = 32'sd0;
    localparam logic signed [31:0] INIT_OUT_RST = 32'sd0;

    localparam logic [CFG_AW-1:0] CFG_IN_MIN   = 3'd0;
    localparam logic [CFG_AW-1:0] CFG_IN_MAX   = 3'd1;
    localparam logic [CFG_AW-1:0] CFG_OUT_MIN  = 3'd2;
    localparam logic [CFG_AW-1:0] CFG_OUT_MAX  = 3'd3;
    localparam logic [CFG_AW-1:0] CFG_GAIN     = 3'd4;
    localparam logic [CFG_AW-1:0] CFG_TAU      = 3'd5;
    localparam logic [CFG_AW-1:0] CFG_INIT_IN  = 3'd6;
    localparam logic [CFG_AW-1:0] CFG_INIT_OUT = 3'd7;

    localparam logic [1:0] STATUS_OK      = 2'd0;
    localparam logic [1:0] STATUS_DT_BAD  = 2'd1;
    localparam logic [1:0] STATUS_CFG_BAD = 2'd2;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_STEP,
        RES_ERR,
        RES_RESTART
    } res_kind_t;

    typedef enum logic [3:0] {
        ST_FILL,
        ST_IDLE,
        ST_CHECK,
        ST_IN_WR,
        ST_IN_RD,
        ST_MUL1,
        ST_NUM,
        ST_DINIT,
        ST_DIV,
        ST_RATE,
        ST_MUL2,
        ST_SUM,
        ST_OUT_WR,
        ST_OUT_RD,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic      load;
        logic      fill_start;
        logic      fill_step;
        logic      in_wr;
        logic      in_rd;
        logic      mul1;
        logic      num;
        logic      dinit;
        logic      dstep;
        logic      rate;
        logic      mul2;
        logic      sum;
        logic      out_wr;
        logic      out_rd;
        logic      emit;
        res_kind_t kind;
    } cmd_t;

    typedef struct packed {
        logic cfg_bad;
        logic restart;
        logic dt_bad;
        logic fill_last;
        logic div_last;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== hw/rtl/fopdt_datapath.sv =====
// ----------------------------------------------------------------------------
// fopdt_datapath
// config registers, delay rings, multiplier, radix-4 divider and result register
// ----------------------------------------------------------------------------
`default_nettype none

module fopdt_datapath
    import fopdt_pkg::*;
#(
    parameter int IN_DELAY_LEN  = IN_DELAY_LEN_DEF,
    parameter int OUT_DELAY_LEN = OUT_DELAY_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_AW-1:0]     cfg_addr,
    input  wire logic [DATA_W-1:0]     cfg_wdata,
    input  wire logic                  s_tuser,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [M_TDATA_W-1:0]       m_tdata,
    input  wire cmd_t                  cmd,
    output sts_t                       sts
);

    localparam int FILL_LEN = (IN_DELAY_LEN > OUT_DELAY_LEN) ? IN_DELAY_LEN : OUT_DELAY_LEN;
    localparam int FW  = (FILL_LEN > 1) ? $clog2(FILL_LEN) : 1;
    localparam int IIW = (IN_DELAY_LEN > 1) ? $clog2(IN_DELAY_LEN) : 1;
    localparam int OIW = (OUT_DELAY_LEN > 1) ? $clog2(OUT_DELAY_LEN) : 1;

    // configuration
    logic signed [31:0] in_min_reg, in_max_reg, out_min_reg, out_max_reg;
    logic signed [31:0] gain_reg, tau_reg, init_in_reg, init_out_reg;

    // captured item
    logic               func_reg;
    logic signed [31:0] drive_reg, dist_reg, dt_reg, inoise_reg, onoise_reg;

    // state
    logic [IIW-1:0]     in_idx_reg;
    logic [OIW-1:0]     out_idx_reg;
    logic [FW-1:0]      fcnt_reg;
    logic signed [31:0] prev_reg, meas_reg;
    logic signed [31:0] in_mem  [IN_DELAY_LEN];
    logic signed [31:0] out_mem [OUT_DELAY_LEN];
    logic signed [31:0] in_rdata_reg, out_rdata_reg;

    // arithmetic
    logic signed [63:0] prod_reg, num_reg;
    logic               neg_reg;
    logic [63:0]        dq_reg;
    logic [30:0]        rem_reg;
    logic [DIV_CNT_W-1:0] dcnt_reg;
    logic signed [31:0] rate_reg, outv_reg;

    // result register
    logic               m_valid_reg;
    logic signed [31:0] m_meas_reg, m_plant_reg, m_applied_reg;
    logic [1:0]         m_status_reg;

    logic               cfg_bad;
    logic signed [32:0] noisy_sum;
    logic signed [31:0] noisy;
    logic               in_we, out_we;
    logic [IIW-1:0]     in_waddr;
    logic [OIW-1:0]     out_waddr;
    logic signed [31:0] in_wdata, out_wdata;
    logic [31:0]        t1, t2, r1, r2;
    logic               b1, b2;
    logic signed [31:0] rate_c;
    logic signed [47:0] p2_sh;
    logic signed [48:0] trunc;
    logic signed [50:0] outv_sum;
    logic signed [31:0] outv_c;

    assign cfg_bad = (in_min_reg >= in_max_reg) || (out_min_reg >= out_max_reg) ||
                     (tau_reg <= 32'sd0) || (init_out_reg < out_min_reg) ||
                     (init_out_reg > out_max_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_min_reg   <= IN_MIN_RST;
            in_max_reg   <= IN_MAX_RST;
            out_min_reg  <= OUT_MIN_RST;
            out_max_reg  <= OUT_MAX_RST;
            gain_reg     <= GAIN_RST;
            tau_reg      <= TAU_RST;
            init_in_reg  <= INIT_IN_RST;
            init_out_reg <= INIT_OUT_RST;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                CFG_IN_MIN:   in_min_reg   <= cfg_wdata;
                CFG_IN_MAX:   in_max_reg   <= cfg_wdata;
                CFG_OUT_MIN:  out_min_reg  <= cfg_wdata;
                CFG_OUT_MAX:  out_max_reg  <= cfg_wdata;
                CFG_GAIN:     gain_reg     <= cfg_wdata;
                CFG_TAU:      tau_reg      <= cfg_wdata;
                CFG_INIT_IN:  init_in_reg  <= cfg_wdata;
                CFG_INIT_OUT: init_out_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg   <= s_tuser;
            drive_reg  <= s_tdata[31:0];
            dist_reg   <= s_tdata[63:32];
            dt_reg     <= s_tdata[95:64];
            inoise_reg <= s_tdata[127:96];
            onoise_reg <= s_tdata[159:128];
        end
    end

    // noisy drive, clamped
    assign noisy_sum = {drive_reg[31], drive_reg} + {inoise_reg[31], inoise_reg};
    always_comb begin
        if (noisy_sum > 33'(in_max_reg)) begin
            noisy = in_max_reg;
        end else if (noisy_sum < 33'(in_min_reg)) begin
            noisy = in_min_reg;
        end else begin
            noisy = noisy_sum[31:0];
        end
    end

    // ring ports: fill sweep or one step write
    assign in_we     = (cmd.fill_step && (fcnt_reg < IN_DELAY_LEN)) || cmd.in_wr;
    assign in_waddr  = cmd.fill_step ? fcnt_reg[IIW-1:0] : in_idx_reg;
    assign in_wdata  = cmd.fill_step ? init_in_reg : noisy;
    assign out_we    = (cmd.fill_step && (fcnt_reg < OUT_DELAY_LEN)) || cmd.out_wr;
    assign out_waddr = cmd.fill_step ? fcnt_reg[OIW-1:0] : out_idx_reg;
    assign out_wdata = cmd.fill_step ? init_out_reg : outv_reg;

    always_ff @(posedge aclk) begin
        if (in_we) begin
            in_mem[in_waddr] <= in_wdata;
        end
        if (cmd.in_rd) begin
            in_rdata_reg <= in_mem[in_idx_reg];
        end
        if (out_we) begin
            out_mem[out_waddr] <= out_wdata;
        end
        if (cmd.out_rd) begin
            out_rdata_reg <= out_mem[out_idx_reg];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_idx_reg  <= '0;
            out_idx_reg <= '0;
            fcnt_reg    <= '0;
            prev_reg    <= INIT_OUT_RST;
            meas_reg    <= INIT_OUT_RST;
        end else begin
            if (cmd.fill_start) begin
                in_idx_reg  <= '0;
                out_idx_reg <= '0;
                fcnt_reg    <= '0;
                prev_reg    <= init_out_reg;
                meas_reg    <= init_out_reg;
            end else if (cmd.fill_step) begin
                fcnt_reg <= fcnt_reg + FW'(1);
            end
            if (cmd.in_wr) begin
                in_idx_reg <= (in_idx_reg == IIW'(IN_DELAY_LEN - 1)) ? '0 : in_idx_reg + IIW'(1);
            end
            if (cmd.out_wr) begin
                out_idx_reg <= (out_idx_reg == OIW'(OUT_DELAY_LEN - 1)) ?
                               '0 : out_idx_reg + OIW'(1);
                prev_reg    <= outv_reg;
            end
            if (cmd.emit && (cmd.kind == RES_STEP)) begin
                meas_reg <= out_rdata_reg;
            end
        end
    end

    // two quotient bits per step
    always_comb begin
        t1 = {rem_reg, dq_reg[63]};
        b1 = t1 >= {1'b0, tau_reg[30:0]};
        r1 = b1 ? t1 - {1'b0, tau_reg[30:0]} : t1;
        t2 = {r1[30:0], dq_reg[62]};
        b2 = t2 >= {1'b0, tau_reg[30:0]};
        r2 = b2 ? t2 - {1'b0, tau_reg[30:0]} : t2;
    end

    // signed quotient saturated to 32 bits
    always_comb begin
        if (!neg_reg) begin
            rate_c = (dq_reg > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : dq_reg[31:0];
        end else begin
            rate_c = (dq_reg > 64'h8000_0000) ? 32'sh8000_0000 : -dq_reg[31:0];
        end
    end

    // dt*rate to q16.16 toward zero, then the output sum and clamp
    assign p2_sh    = prod_reg[63:16];
    assign trunc    = {p2_sh[47], p2_sh} +
                      49'(prod_reg[63] && (prod_reg[15:0] != 16'd0));
    assign outv_sum = 51'(prev_reg) + 51'(trunc) + 51'(onoise_reg);
    always_comb begin
        if (outv_sum > 51'(out_max_reg)) begin
            outv_c = out_max_reg;
        end else if (outv_sum < 51'(out_min_reg)) begin
            outv_c = out_min_reg;
        end else begin
            outv_c = outv_sum[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul1) begin
            prod_reg <= gain_reg * in_rdata_reg;
        end else if (cmd.mul2) begin
            prod_reg <= dt_reg * rate_reg;
        end
        if (cmd.num) begin
            num_reg <= prod_reg - (64'(prev_reg) <<< Q_FRAC) + (64'(dist_reg) <<< Q_FRAC);
        end
        if (cmd.dinit) begin
            neg_reg  <= num_reg[63];
            dq_reg   <= num_reg[63] ? 64'(-num_reg) : 64'(num_reg);
            rem_reg  <= '0;
            dcnt_reg <= '0;
        end else if (cmd.dstep) begin
            dq_reg   <= {dq_reg[61:0], b1, b2};
            rem_reg  <= r2[30:0];
            dcnt_reg <= dcnt_reg + DIV_CNT_W'(1);
        end
        if (cmd.rate) begin
            rate_reg <= rate_c;
        end
        if (cmd.sum) begin
            outv_reg <= outv_c;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            unique case (cmd.kind)
                RES_STEP: begin
                    m_meas_reg    <= out_rdata_reg;
                    m_plant_reg   <= outv_reg;
                    m_applied_reg <= in_rdata_reg;
                    m_status_reg  <= STATUS_OK;
                end
                RES_RESTART: begin
                    m_meas_reg    <= init_out_reg;
                    m_plant_reg   <= init_out_reg;
                    m_applied_reg <= '0;
                    m_status_reg  <= STATUS_OK;
                end
                default: begin
                    m_meas_reg    <= meas_reg;
                    m_plant_reg   <= prev_reg;
                    m_applied_reg <= '0;
                    m_status_reg  <= cfg_bad ? STATUS_CFG_BAD : STATUS_DT_BAD;
                end
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {6'd0, m_status_reg, m_applied_reg, m_plant_reg, m_meas_reg};

    assign sts.cfg_bad   = cfg_bad;
    assign sts.restart   = func_reg;
    assign sts.dt_bad    = (dt_reg <= 32'sd0);
    assign sts.fill_last = (fcnt_reg == FW'(FILL_LEN - 1));
    assign sts.div_last  = (dcnt_reg == DIV_CNT_W'(DIV_STEPS - 1));
    assign sts.out_free  = !m_valid_reg || m_tready;

endmodule

`default_nettype wire

// ===== hw/rtl/fopdt_ctrl.sv =====
// ----------------------------------------------------------------------------
// fopdt_ctrl
// sequencer that walks one item through the datapath
// ----------------------------------------------------------------------------
`default_nettype none

module fopdt_ctrl
    import fopdt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_tvalid,
    output logic      s_tready,
    input  wire sts_t sts,
    output cmd_t      cmd
);

    state_t    state_reg, state_next;
    res_kind_t kind_reg, kind_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_FILL;
            kind_reg  <= RES_NONE;
        end else begin
            state_reg <= state_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        kind_next  = kind_reg;
        unique case (state_reg)
            ST_FILL: begin
                if (sts.fill_last) begin
                    state_next = (kind_reg == RES_RESTART) ? ST_EMIT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK: begin
                priority if (sts.cfg_bad) begin
                    kind_next  = RES_ERR;
                    state_next = ST_EMIT;
                end else if (sts.restart) begin
                    kind_next  = RES_RESTART;
                    state_next = ST_FILL;
                end else if (sts.dt_bad) begin
                    kind_next  = RES_ERR;
                    state_next = ST_EMIT;
                end else begin
                    kind_next  = RES_STEP;
                    state_next = ST_IN_WR;
                end
            end
            ST_IN_WR:  state_next = ST_IN_RD;
            ST_IN_RD:  state_next = ST_MUL1;
            ST_MUL1:   state_next = ST_NUM;
            ST_NUM:    state_next = ST_DINIT;
            ST_DINIT:  state_next = ST_DIV;
            ST_DIV: begin
                if (sts.div_last) begin
                    state_next = ST_RATE;
                end
            end
            ST_RATE:   state_next = ST_MUL2;
            ST_MUL2:   state_next = ST_SUM;
            ST_SUM:    state_next = ST_OUT_WR;
            ST_OUT_WR: state_next = ST_OUT_RD;
            ST_OUT_RD: state_next = ST_EMIT;
            ST_EMIT: begin
                if (sts.out_free) begin
                    state_next = ST_IDLE;
                    kind_next  = RES_NONE;
                end
            end
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        cmd            = '0;
        cmd.kind       = kind_reg;
        cmd.load       = (state_reg == ST_IDLE) && s_tvalid;
        cmd.fill_start = (state_reg == ST_CHECK) && !sts.cfg_bad && sts.restart;
        cmd.fill_step  = (state_reg == ST_FILL);
        cmd.in_wr      = (state_reg == ST_IN_WR);
        cmd.in_rd      = (state_reg == ST_IN_RD);
        cmd.mul1       = (state_reg == ST_MUL1);
        cmd.num        = (state_reg == ST_NUM);
        cmd.dinit      = (state_reg == ST_DINIT);
        cmd.dstep      = (state_reg == ST_DIV);
        cmd.rate       = (state_reg == ST_RATE);
        cmd.mul2       = (state_reg == ST_MUL2);
        cmd.sum        = (state_reg == ST_SUM);
        cmd.out_wr     = (state_reg == ST_OUT_WR);
        cmd.out_rd     = (state_reg == ST_OUT_RD);
        cmd.emit       = (state_reg == ST_EMIT) && sts.out_free;
    end

    assign s_tready = (state_reg == ST_IDLE);

endmodule

`default_nettype wire

// ===== hw/rtl/first_order_plant_with_dead_time.sv =====
// step item: the walk from beat to result runs through the 32-step radix-4 divider
// error item: straight to the result; restart item: a ring fill sweep, then the result
// one item at a time, next beat in the cycle after the result is loaded;
// loading waits only while an earlier result is still held
// reset: synchronous, active low; then a ring fill sweep of
// max(IN_DELAY_LEN, OUT_DELAY_LEN) entries with s_tready low
// ----------------------------------------------------------------------------
// first_order_plant_with_dead_time
// q16.16 first-order plant with input and output dead-time rings
// ----------------------------------------------------------------------------
`default_nettype none

module first_order_plant_with_dead_time
    import fopdt_pkg::*;
#(
    parameter int IN_DELAY_LEN  = IN_DELAY_LEN_DEF,
    parameter int OUT_DELAY_LEN = OUT_DELAY_LEN_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_AW-1:0]     cfg_addr,
    input  wire logic [DATA_W-1:0]     cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // drive_input, disturbance, time_step, input_noise, output_noise
    input  wire logic [S_TDATA_W-1:0]  s_tdata,
    // func
    input  wire logic                  s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // measured_output, plant_output, applied_input, status, zero pad
    output logic [M_TDATA_W-1:0]       m_tdata
);

    cmd_t cmd;
    sts_t sts;

    fopdt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    fopdt_datapath #(
        .IN_DELAY_LEN  (IN_DELAY_LEN),
        .OUT_DELAY_LEN (OUT_DELAY_LEN)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cmd       (cmd),
        .sts       (sts)
    );

endmodule

`default_nettype wire

// ===== hw/rtl/fopdt_checker.sv =====
// ----------------------------------------------------------------------------
// fopdt_checker
// port-level checks of the plant block, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "first_order_plant_with_dead_time_defines.svh"

module fopdt_checker
    import fopdt_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // busy in the cycle after a beat
    `FOPDT_ASSERT_NEXT(a_busy_after_beat, aclk, aresetn, s_tvalid && s_tready, !s_tready)
    // ring fill runs after reset before any beat is taken
    `FOPDT_ASSERT_NEXT(a_no_ready_after_reset, aclk, 1'b1, !aresetn, !s_tready)
    // error results report no applied input
    `FOPDT_ASSERT_IMPL(a_err_applied_zero, aclk, aresetn, m_tvalid && (m_tdata[97:96] != STATUS_OK), m_tdata[95:64] == 32'd0)
    `FOPDT_ASSERT_NEXT(a_m_valid_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid)
    `FOPDT_ASSERT_NEXT(a_m_data_hold, aclk, aresetn, m_tvalid && !m_tready, $stable(m_tdata))

endmodule

bind first_order_plant_with_dead_time fopdt_checker u_fopdt_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
